// File: rtl/ncbm_pkg.sv
// Shared types, constants and codes for the nixie crossfade / blink display driver.
// No dependencies; every other file imports this package.
`timescale 1ns / 1ps

package ncbm_pkg;

	// Fade and blink timing
	localparam int FADE_TICKS    = 512;
	localparam int BLINK_PERIOD  = 2048;
	localparam int FADE_QUARTER  = FADE_TICKS / 4;
	localparam int BLINK_HALF    = BLINK_PERIOD / 2;

	localparam int FL_W = $clog2(FADE_TICKS + 1);
	localparam int BC_W = $clog2(BLINK_PERIOD);

	// Word widths
	localparam int WORD_W  = 16;
	localparam int DUTY_W  = 3;
	localparam int MODE_W  = 2;
	localparam int CFG_IDX_W = 2;
	localparam int CFG_DATA_W = 3;

	// Blanking masks
	localparam logic [WORD_W-1:0] MASK_HOURS   = 16'hff00;
	localparam logic [WORD_W-1:0] MASK_MINUTES = 16'h00ff;
	localparam logic [WORD_W-1:0] MASK_MIDDLE  = 16'h0ff0;
	localparam logic [WORD_W-1:0] MASK_KEEP_M1 = 16'hff0f;
	localparam logic [WORD_W-1:0] MASK_ALL     = 16'hffff;
	localparam logic [WORD_W-1:0] M1_FIELD     = 16'h00f0;
	localparam logic [WORD_W-1:0] M1_TWO       = 16'h0020;
	localparam logic [WORD_W-1:0] WORD_BLANK   = 16'hffff;

	// Action codes of an input transaction
	localparam logic ACT_TICK  = 1'b0;
	localparam logic ACT_START = 1'b1;

	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_TUBE_DUTY  = 2'd0,
		CFG_BLINK_MODE = 2'd1,
		CFG_BLINK_DUTY = 2'd2
	} cfg_index_t;

	typedef enum logic [MODE_W-1:0] {
		BLINK_OFF     = 2'd0,
		BLINK_HOURS   = 2'd1,
		BLINK_MINUTES = 2'd2,
		BLINK_FULL    = 2'd3
	} blink_mode_t;

	typedef struct packed {
		logic [DUTY_W-1:0] tube_duty;
		blink_mode_t       blink_mode;
		logic [DUTY_W-1:0] blink_duty;
	} cfg_t;

	typedef struct packed {
		logic [WORD_W-1:0] shown_value;
		logic [WORD_W-1:0] target_value;
		logic              fade_armed;
		logic [FL_W-1:0]   fade_left;
		logic [2:0]        old_share;
		logic [1:0]        dither_phase;
		logic [BC_W-1:0]   blink_count;
		logic [DUTY_W-1:0] eff_bright;
		logic [3:0]        scan_slot;
	} state_t;

	typedef struct packed {
		logic [WORD_W-1:0] display_word;
		logic [3:0]        port_a_bits;
		logic [3:0]        port_b_bits;
		logic [7:0]        port_c_bits;
		logic              blink_edge;
	} result_t;

	localparam state_t STATE_RESET = '{
		shown_value:  WORD_BLANK,
		target_value: WORD_BLANK,
		fade_armed:   1'b0,
		fade_left:    '0,
		old_share:    3'd0,
		dither_phase: 2'd0,
		blink_count:  '0,
		eff_bright:   '0,
		scan_slot:    4'd0
	};

	// Tube pin order for tens-of-minutes and hour digits
	function automatic logic [3:0] nib_swizzle(input logic [3:0] d);
		nib_swizzle = {d[0], d[3], d[1], d[2]};
	endfunction

endpackage

// File: rtl/ncbm_if.sv
// Handshake channels of the nixie display driver: input transactions and results.
// Depends on ncbm_pkg for widths.
`timescale 1ns / 1ps

interface ncbm_in_if;
	import ncbm_pkg::*;
	logic              valid;
	logic              ready;
	logic              action;
	logic [WORD_W-1:0] new_value;

	modport source (output valid, action, new_value, input ready);
	modport sink   (input valid, action, new_value, output ready);
endinterface

interface ncbm_out_if;
	import ncbm_pkg::*;
	logic              valid;
	logic              ready;
	logic [WORD_W-1:0] display_word;
	logic [3:0]        port_a_bits;
	logic [3:0]        port_b_bits;
	logic [7:0]        port_c_bits;
	logic              blink_edge;

	modport source (output valid, display_word, port_a_bits, port_b_bits, port_c_bits,
		blink_edge, input ready);
	modport sink   (input valid, display_word, port_a_bits, port_b_bits, port_c_bits,
		blink_edge, output ready);
endinterface

// File: rtl/nixie_crossfade_blink_mux.sv
// Top level of the four-digit nixie display driver with crossfade and blinking.
// Depends on ncbm_pkg, ncbm_if (ncbm_in_if, ncbm_out_if) and ncbm_step.
//
// Usage:
//   item   : input channel. action 1 (start fade) stores new_value as the target
//            and arms a fade; it produces no result. action 0 is one scan tick.
//   result : one transaction per scan tick: blanked BCD word, rehashed port
//            bits and the blink-edge flag.
//   cfg_we / cfg_index / cfg_data : register writes (0 tube_duty, 1 blink_mode,
//            2 blink_duty), taken on any edge with cfg_we high; other indexes
//            are ignored. Write only while the block is idle.
// Pipeline: an accepted tick is registered in stage 1, then processed into the
//   result register. Throughput: one transaction per cycle unless stalled; the
//   state update is a single pass of counter, compare and mask logic between
//   the stage-1 and result registers.
// Reset: all display state blank/zero, tube_duty 1, blink_mode 0, blink_duty 0.
// Stall: the result register holds while result.ready is low; stage 1 holds a
//   tick behind it, so item.ready drops only when both are full. Start-fade
//   transactions pass through stage 1 even while the result is stalled.
`timescale 1ns / 1ps

module nixie_crossfade_blink_mux
	import ncbm_pkg::*;
(
	input  logic                  clk,
	input  logic                  arst_n,
	ncbm_in_if.sink               item,
	ncbm_out_if.source            result,
	input  logic                  cfg_we,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data
);

	cfg_t              cfg_q;
	state_t            state_q;
	state_t            state_nxt;
	result_t           res_nxt;
	result_t           res_q;
	logic              res_valid_q;

	logic              valid_s1;
	logic              action_s1;
	logic [WORD_W-1:0] value_s1;
	logic              go_s1;

	// Stage 1 moves on when it holds a start, or the result slot can take a tick
	assign go_s1      = valid_s1 && (action_s1 == ACT_START || !res_valid_q || result.ready);
	assign item.ready = !valid_s1 || go_s1;

	// Configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.tube_duty  <= 3'd1;
			cfg_q.blink_mode <= BLINK_OFF;
			cfg_q.blink_duty <= 3'd0;
		end else if (cfg_we) begin
			case (cfg_index)
				CFG_TUBE_DUTY:  cfg_q.tube_duty  <= cfg_data;
				CFG_BLINK_MODE: cfg_q.blink_mode <= blink_mode_t'(cfg_data[MODE_W-1:0]);
				CFG_BLINK_DUTY: cfg_q.blink_duty <= cfg_data;
				default:        cfg_q <= cfg_q;
			endcase
		end
	end

	// Input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (item.ready) begin
			valid_s1 <= item.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (item.ready && item.valid) begin
			action_s1 <= item.action;
			value_s1  <= item.new_value;
		end
	end

	ncbm_step u_step (
		.cur (state_q),
		.cfg (cfg_q),
		.nxt (state_nxt),
		.res (res_nxt)
	);

	// Display state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= STATE_RESET;
		end else if (go_s1) begin
			if (action_s1 == ACT_START) begin
				state_q.target_value <= value_s1;
				state_q.fade_armed   <= 1'b1;
			end else begin
				state_q <= state_nxt;
			end
		end
	end

	// Result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q <= 1'b0;
		end else if (go_s1 && action_s1 == ACT_TICK) begin
			res_valid_q <= 1'b1;
		end else if (result.ready) begin
			res_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (go_s1 && action_s1 == ACT_TICK)
			res_q <= res_nxt;
	end

	assign result.valid        = res_valid_q;
	assign result.display_word = res_q.display_word;
	assign result.port_a_bits  = res_q.port_a_bits;
	assign result.port_b_bits  = res_q.port_b_bits;
	assign result.port_c_bits  = res_q.port_c_bits;
	assign result.blink_edge   = res_q.blink_edge;

endmodule

// File: rtl/ncbm_step.sv
// Next-state and result logic for one scan tick: blink, fade/dither, duty scan, pin map.
// Depends on ncbm_pkg.
`timescale 1ns / 1ps

module ncbm_step
	import ncbm_pkg::*;
(
	input  state_t  cur,
	input  cfg_t    cfg,
	output state_t  nxt,
	output result_t res
);

	always_comb begin
		state_t            s;
		logic [WORD_W-1:0] word;
		logic              edge_flag;
		logic [4:0]        on_slots;
		logic [4:0]        eff_slots;
		logic [5:0]        comp_slots;
		logic [3:0]        h1, h2, m1, m2;

		s         = cur;
		edge_flag = 1'b0;

		// Blink counter and effective brightness
		if (cfg.blink_mode != BLINK_OFF) begin
			if (s.blink_count == BC_W'(BLINK_PERIOD - 1))
				s.blink_count = '0;
			else
				s.blink_count = s.blink_count + 1'b1;
			if (s.blink_count >= BC_W'(BLINK_HALF)) begin
				if (s.eff_bright != cfg.blink_duty)
					edge_flag = 1'b1;
				s.eff_bright = cfg.blink_duty;
			end else begin
				s.eff_bright = cfg.tube_duty;
			end
		end

		// Fade start
		if (s.fade_armed) begin
			s.fade_left    = FL_W'(FADE_TICKS);
			s.old_share    = 3'd4;
			s.dither_phase = 2'd0;
			s.fade_armed   = 1'b0;
		end

		// Fade progress: share drops each quarter of the fade
		if (s.fade_left != '0) begin
			s.fade_left = s.fade_left - 1'b1;
			if ((s.fade_left % FL_W'(FADE_QUARTER)) == '0 && s.old_share != 3'd0)
				s.old_share = s.old_share - 3'd1;
			if (s.fade_left == '0) begin
				s.dither_phase = 2'd0;
				s.shown_value  = s.target_value;
			end
		end

		// Dither between old and new word
		word = ({1'b0, s.dither_phase} < s.old_share) ? s.shown_value : s.target_value;
		s.dither_phase = s.dither_phase + 2'd1;

		// Duty scan blanking
		on_slots   = {cfg.tube_duty, 2'b00};
		eff_slots  = {s.eff_bright, 2'b00};
		comp_slots = {({1'b0, cfg.tube_duty} + 4'd1), 2'b00};
		if ({1'b0, s.scan_slot} < on_slots) begin
			if ({1'b0, s.scan_slot} >= eff_slots) begin
				case (cfg.blink_mode)
					BLINK_HOURS:   word = word | MASK_HOURS;
					BLINK_MINUTES: word = word | MASK_MINUTES;
					BLINK_FULL:    word = word | MASK_ALL;
					default:       word = word;
				endcase
			end
			if (cfg.tube_duty > 3'd2 && s.scan_slot < 4'd4)
				word = word | MASK_MIDDLE;
		end else begin
			// Low brightness compensation keeps a "2" tens-of-minutes digit lit longer
			if (cfg.tube_duty < 3'd3 && {2'b00, s.scan_slot} < comp_slots &&
				(word & M1_FIELD) == M1_TWO && cfg.blink_mode == BLINK_OFF)
				word = word | MASK_KEEP_M1;
			else
				word = word | MASK_ALL;
		end
		s.scan_slot = s.scan_slot + 4'd1;

		h1 = word[15:12];
		h2 = word[11:8];
		m1 = word[7:4];
		m2 = word[3:0];

		nxt              = s;
		res.display_word = word;
		res.port_a_bits  = {m2[2], m2[1], m2[3], m2[0]};
		res.port_b_bits  = nib_swizzle(m1);
		res.port_c_bits  = {nib_swizzle(h1), nib_swizzle(h2)};
		res.blink_edge   = edge_flag;
	end

endmodule

// File: tb/nixie_crossfade_blink_mux_tb.sv
// Self-checking testbench for the nixie crossfade / blink display driver.
// Depends on ncbm_pkg, ncbm_if and nixie_crossfade_blink_mux; predicts every scan tick.
`timescale 1ns / 1ps

module nixie_crossfade_blink_mux_tb;
	import ncbm_pkg::*;

	localparam int            IDLE_LIMIT  = 3000;
	localparam int            LONG_HOLD   = 300;
	localparam int            ITEM_TARGET = 950;
	localparam logic [CFG_IDX_W-1:0] CFG_SPARE = 2'd3;

	// Scoreboard: shadow copy of the display state plus the queue of expected frames
	class tube_scoreboard;
		logic [DUTY_W-1:0] tube_duty;
		blink_mode_t       blink_mode;
		logic [DUTY_W-1:0] blink_duty;
		logic [WORD_W-1:0] shown;
		logic [WORD_W-1:0] target;
		bit                armed;
		int                fade_left;
		int                old_share;
		int                dither;
		int                blink_cnt;
		int                eff_bright;
		int                slot;
		result_t           expected_frames[$];
		int                errors;

		function new();
			tube_duty   = 3'd1;
			blink_mode  = BLINK_OFF;
			blink_duty  = 3'd0;
			shown       = WORD_BLANK;
			target      = WORD_BLANK;
			armed       = 1'b0;
			fade_left   = 0;
			old_share   = 0;
			dither      = 0;
			blink_cnt   = 0;
			eff_bright  = 0;
			slot        = 0;
			errors      = 0;
		endfunction

		function void load_register(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
			case (idx)
				CFG_TUBE_DUTY:  tube_duty = data;
				CFG_BLINK_MODE: blink_mode = blink_mode_t'(data[MODE_W-1:0]);
				CFG_BLINK_DUTY: blink_duty = data;
				default: ;
			endcase
		endfunction

		// Tens-of-minutes / hour pin order
		function logic [3:0] tube_pins(logic [3:0] d);
			return {d[0], d[3], d[1], d[2]};
		endfunction

		// Lowest digit pin order
		function logic [3:0] low_pins(logic [3:0] d);
			return {d[2], d[1], d[3], d[0]};
		endfunction

		// Note an accepted transaction; a scan tick yields one expected frame
		function void take_item(logic act, logic [WORD_W-1:0] value);
			logic [WORD_W-1:0] word;
			bit                edge_flag;
			int                td;
			result_t           frame;
			if (act == ACT_START) begin
				target = value;
				armed  = 1'b1;
				return;
			end
			edge_flag = 1'b0;
			td = int'(tube_duty);

			// blink counter and effective brightness
			if (blink_mode != BLINK_OFF) begin
				blink_cnt = (blink_cnt + 1) % BLINK_PERIOD;
				if (blink_cnt >= BLINK_PERIOD / 2) begin
					if (eff_bright != int'(blink_duty))
						edge_flag = 1'b1;
					eff_bright = int'(blink_duty);
				end else begin
					eff_bright = td;
				end
			end

			// fade progress
			if (armed) begin
				fade_left = FADE_TICKS;
				old_share = 4;
				dither    = 0;
				armed     = 1'b0;
			end
			if (fade_left != 0) begin
				fade_left--;
				if (fade_left % (FADE_TICKS / 4) == 0 && old_share != 0)
					old_share--;
				if (fade_left == 0) begin
					dither = 0;
					shown  = target;
				end
			end
			word   = (dither < old_share) ? shown : target;
			dither = (dither + 1) & 3;

			// duty scan blanking
			if (slot < td * 4) begin
				if (slot >= eff_bright * 4) begin
					case (blink_mode)
						BLINK_HOURS:   word |= MASK_HOURS;
						BLINK_MINUTES: word |= MASK_MINUTES;
						BLINK_FULL:    word |= MASK_ALL;
						default: ;
					endcase
				end
				if (td > 2 && slot < 4)
					word |= MASK_MIDDLE;
			end else begin
				if (td < 3 && slot < (td + 1) * 4 && (word & M1_FIELD) == M1_TWO &&
					blink_mode == BLINK_OFF)
					word |= MASK_KEEP_M1;
				else
					word |= MASK_ALL;
			end
			slot = (slot + 1) & 15;

			frame.display_word = word;
			frame.port_a_bits  = low_pins(word[3:0]);
			frame.port_b_bits  = tube_pins(word[7:4]);
			frame.port_c_bits  = {tube_pins(word[15:12]), tube_pins(word[11:8])};
			frame.blink_edge   = edge_flag;
			expected_frames.push_back(frame);
		endfunction

		// Compare an accepted result with the oldest expected frame
		function void check_frame(result_t got);
			result_t exp_f;
			if (expected_frames.size() == 0) begin
				$error("unexpected result transaction: display_word %h", got.display_word);
				errors++;
				return;
			end
			exp_f = expected_frames.pop_front();
			if (got.display_word !== exp_f.display_word) begin
				$error("display_word: expected %h, got %h", exp_f.display_word,
					got.display_word);
				errors++;
			end
			if (got.port_a_bits !== exp_f.port_a_bits) begin
				$error("port_a_bits: expected %h, got %h", exp_f.port_a_bits,
					got.port_a_bits);
				errors++;
			end
			if (got.port_b_bits !== exp_f.port_b_bits) begin
				$error("port_b_bits: expected %h, got %h", exp_f.port_b_bits,
					got.port_b_bits);
				errors++;
			end
			if (got.port_c_bits !== exp_f.port_c_bits) begin
				$error("port_c_bits: expected %h, got %h", exp_f.port_c_bits,
					got.port_c_bits);
				errors++;
			end
			if (got.blink_edge !== exp_f.blink_edge) begin
				$error("blink_edge: expected %b, got %b", exp_f.blink_edge, got.blink_edge);
				errors++;
			end
		endfunction
	endclass

	logic                  clk;
	logic                  arst_n;
	logic                  cfg_we;
	logic [CFG_IDX_W-1:0]  cfg_index;
	logic [CFG_DATA_W-1:0] cfg_data;

	ncbm_in_if  item_ch();
	ncbm_out_if res_ch();

	tube_scoreboard sb;
	int  sent;
	int  idle_cycles;
	bit  sender_quiet;
	bit  hold_req;

	nixie_crossfade_blink_mux DUT (
		.clk       (clk),
		.arst_n    (arst_n),
		.item      (item_ch),
		.result    (res_ch),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	initial clk = 1'b0;
	always #10 clk = ~clk;

	// Sender gap: mostly back-to-back, some short, a few long
	function automatic int pick_gap();
		int r;
		r = $urandom_range(0, 99);
		if (sender_quiet || r < 60)
			return 0;
		if (r < 92)
			return $urandom_range(1, 3);
		return $urandom_range(8, 40);
	endfunction

	// Display word: mostly BCD digits, some blanks, some out-of-range nibbles
	function automatic logic [WORD_W-1:0] pick_word();
		logic [WORD_W-1:0] w;
		int                r;
		if ($urandom_range(0, 9) == 0)
			return WORD_W'($urandom);
		for (int n = 0; n < 4; n++) begin
			r = $urandom_range(0, 99);
			if (r < 70)
				w[n*4 +: 4] = 4'($urandom_range(0, 9));
			else if (r < 85)
				w[n*4 +: 4] = 4'hf;
			else
				w[n*4 +: 4] = 4'($urandom_range(10, 14));
		end
		// tens-of-minutes digit 2 triggers the partial blank rule
		if ($urandom_range(0, 7) == 0)
			w[7:4] = 4'd2;
		return w;
	endfunction

	// Offer one transaction and wait for it to be taken
	task automatic send_item(logic act, logic [WORD_W-1:0] value);
		int gap;
		gap = pick_gap();
		if (gap > 0) begin
			item_ch.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		item_ch.valid     <= 1'b1;
		item_ch.action    <= act;
		item_ch.new_value <= value;
		do @(posedge clk); while (!item_ch.ready);
		sb.take_item(act, value);
		sent++;
	endtask

	task automatic send_tick();
		send_item(ACT_TICK, WORD_W'($urandom));
	endtask

	task automatic set_register(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
		cfg_we    <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= data;
		sb.load_register(idx, data);
		@(posedge clk);
	endtask

	// Wait until every frame is in, then let a start-fade in flight settle
	task automatic settle();
		item_ch.valid <= 1'b0;
		while (sb.expected_frames.size() != 0) @(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	task automatic random_config();
		logic [CFG_DATA_W-1:0] duty;
		int                    r;
		r = $urandom_range(0, 99);
		if (r < 15)
			duty = (r < 5) ? 3'd0 : 3'($urandom_range(5, 7));
		else
			duty = 3'($urandom_range(1, 4));
		set_register(CFG_TUBE_DUTY, duty);
		if ($urandom_range(0, 3) == 0)
			set_register(CFG_BLINK_MODE, {1'($urandom), BLINK_OFF});
		else
			set_register(CFG_BLINK_MODE, 3'($urandom_range(0, 7)));
		set_register(CFG_BLINK_DUTY, 3'($urandom_range(0, 7)));
		if ($urandom_range(0, 9) == 0)
			set_register(CFG_SPARE, 3'($urandom_range(0, 7)));
		cfg_we <= 1'b0;
	endtask

	// Result sink: ready pattern with stalls, free-running stretches and long holds
	initial begin
		int r;
		forever begin
			if (hold_req) begin
				hold_req = 1'b0;
				res_ch.ready <= 1'b0;
				repeat (LONG_HOLD) @(posedge clk);
			end else begin
				r = $urandom_range(0, 99);
				if (r < 55) begin
					res_ch.ready <= 1'b1;
					repeat ($urandom_range(1, 30)) @(posedge clk);
				end else if (r < 92) begin
					res_ch.ready <= 1'b0;
					repeat ($urandom_range(1, 3)) @(posedge clk);
				end else begin
					res_ch.ready <= 1'b0;
					repeat ($urandom_range(10, 40)) @(posedge clk);
				end
			end
		end
	end

	// Result monitor and watchdog
	always @(posedge clk) begin
		result_t got;
		if (arst_n) begin
			if (res_ch.valid && res_ch.ready) begin
				got.display_word = res_ch.display_word;
				got.port_a_bits  = res_ch.port_a_bits;
				got.port_b_bits  = res_ch.port_b_bits;
				got.port_c_bits  = res_ch.port_c_bits;
				got.blink_edge   = res_ch.blink_edge;
				sb.check_frame(got);
			end
			if ((res_ch.valid && res_ch.ready) || (item_ch.valid && item_ch.ready))
				idle_cycles = 0;
			else
				idle_cycles++;
			if (idle_cycles >= IDLE_LIMIT) begin
				$display("status: fail");
				$finish;
			end
		end
	end

	// Stimulus
	initial begin
		int phase;
		int len;
		bit noisy;
		sb           = new();
		sent         = 0;
		idle_cycles  = 0;
		sender_quiet = 1'b0;
		hold_req     = 1'b0;
		arst_n            <= 1'b0;
		cfg_we            <= 1'b0;
		cfg_index         <= CFG_TUBE_DUTY;
		cfg_data          <= '0;
		item_ch.valid     <= 1'b0;
		item_ch.action    <= ACT_TICK;
		item_ch.new_value <= '0;
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed: blank after reset, word extremes, partial blank, restarts
		send_tick();
		send_item(ACT_START, 16'h0000);
		repeat (3) send_tick();
		send_item(ACT_START, 16'h1220);
		repeat (4) send_tick();
		send_item(ACT_START, WORD_BLANK);
		send_item(ACT_START, 16'h5a5a);
		repeat (4) send_tick();

		// Directed: full brightness, blink everything, spare index ignored
		settle();
		set_register(CFG_TUBE_DUTY, 3'd4);
		set_register(CFG_BLINK_MODE, {1'b1, BLINK_FULL});
		set_register(CFG_BLINK_DUTY, 3'd0);
		set_register(CFG_SPARE, 3'd7);
		cfg_we <= 1'b0;
		repeat (6) send_tick();

		// Directed: zero brightness, widest blink duty
		settle();
		set_register(CFG_TUBE_DUTY, 3'd0);
		set_register(CFG_BLINK_DUTY, 3'd7);
		cfg_we <= 1'b0;
		repeat (3) send_tick();

		// Random phases: well-formed fades with long tick runs, some noisy phases
		phase = 0;
		while (sent < ITEM_TARGET) begin
			settle();
			random_config();
			len          = $urandom_range(30, 250);
			noisy        = ($urandom_range(0, 9) < 3);
			sender_quiet = ($urandom_range(0, 3) == 0);
			// long receiver hold: keep offering well past the point where it starts
			if (phase == 2 || phase == 7) begin
				hold_req = 1'b1;
				len      = LONG_HOLD;
			end
			if (!noisy && $urandom_range(0, 9) < 7)
				send_item(ACT_START, pick_word());
			for (int i = 0; i < len; i++) begin
				if (noisy ? ($urandom_range(0, 5) == 0) : ($urandom_range(0, 299) == 0))
					send_item(ACT_START, pick_word());
				else
					send_tick();
			end
			phase++;
		end

		// Drain and finish
		item_ch.valid <= 1'b0;
		while (sb.expected_frames.size() != 0) @(posedge clk);
		repeat (10) @(posedge clk);
		if (sb.expected_frames.size() != 0) begin
			$error("%0d expected frames never arrived", sb.expected_frames.size());
			sb.errors++;
		end
		if (sb.errors == 0)
			$display("status: pass");
		else
			$display("status: fail");
		$finish;
	end

endmodule

// File: sim.f
rtl/ncbm_pkg.sv
rtl/ncbm_if.sv
rtl/ncbm_step.sv
rtl/nixie_crossfade_blink_mux.sv
tb/nixie_crossfade_blink_mux_tb.sv
